// File: sv/savest_pkg.sv
// ----------------------------------------------------------------------------
// savest_pkg
// Shared types and constants for the servo angle / velocity estimator.
// ----------------------------------------------------------------------------
package savest_pkg;

    // Stream payload widths
    localparam int unsigned POT_W       = 16;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned ANGLE_OUT_W = 16;
    localparam int unsigned VEL_W       = 32;
    localparam int unsigned IN_DATA_W   = 48;   // pot_position, sample_time_us
    localparam int unsigned OUT_DATA_W  = 48;   // angle, velocity

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN    = 3'd0,
        CFG_DZ_LOW  = 3'd1,
        CFG_DZ_HIGH = 3'd2,
        CFG_WEIGHT  = 3'd3,
        CFG_SKIP    = 3'd4
    } t_cfg_addr;

    localparam logic [15:0]        GAIN_RST    = 16'd11185;
    localparam logic signed [15:0] DZ_LOW_RST  = -16'sd166;
    localparam logic signed [15:0] DZ_HIGH_RST = 16'sd1162;
    localparam logic [15:0]        WEIGHT_RST  = 16'd3277;
    localparam logic [3:0]         SKIP_RST    = 4'd1;

    typedef struct packed {
        logic [15:0]        gain;
        logic signed [15:0] dz_low;
        logic signed [15:0] dz_high;
        logic [15:0]        weight;
        logic [3:0]         skip_n;
    } t_cfg;

    // Arithmetic
    localparam int unsigned US_PER_SEC  = 1000000;
    localparam int unsigned HALF_SEC_US = 500000;
    localparam int unsigned DVD_W       = 64;   // divider dividend / quotient
    localparam int unsigned DSR_W       = 32;   // divider divisor / remainder
    localparam int unsigned DIV_BITS    = 2;    // quotient bits per cycle
    localparam int unsigned DIV_ITERS   = DVD_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_ITERS);
    localparam int unsigned MV_W        = 48;   // clamped measured velocity
    localparam int unsigned ACC_W       = 64;   // averaging accumulator
    localparam logic [DVD_W-1:0]        MEAS_LIMIT = 64'h0000_4000_0000_0000;
    localparam logic signed [ACC_W-1:0] VEL_MAX    = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] VEL_MIN    = -64'sd2147483648;
    localparam logic signed [ACC_W-1:0] RND_POS    = 64'sd32768;
    localparam logic signed [ACC_W-1:0] RND_NEG    = 64'sd32767;

    // Sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SETUP,
        ST_LOAD,
        ST_DIVIDE,
        ST_CLAMP,
        ST_MULT,
        ST_SUM,
        ST_ROUND,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic decode;
        logic setup;
        logic load;
        logic div_step;
        logic clamp;
        logic mult;
        logic sum;
        logic round;
        logic apply;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic extrap;
        logic vel_upd;
        logic div_last;
    } t_status;

endpackage

// File: sv/savest_div.sv
// ----------------------------------------------------------------------------
// savest_div
// Unsigned restoring divider, two quotient bits per cycle while i_step is high.
// ----------------------------------------------------------------------------
module savest_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_step,
    input  logic [savest_pkg::DVD_W-1:0]  i_dividend,
    input  logic [savest_pkg::DSR_W-1:0]  i_divisor,
    output logic [savest_pkg::DVD_W-1:0]  o_quotient,
    output logic                          o_last
);
    import savest_pkg::*;

    logic [DSR_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_qd;     // dividend shifts out the top, quotient in
    logic [DSR_W-1:0]     r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0]     n_rem;
    logic [DVD_W-1:0]     n_qd;

    always_comb begin
        logic [DSR_W:0] v_tmp;
        n_rem = r_rem;
        n_qd  = r_qd;
        for (int i = 0; i < DIV_BITS; i++) begin
            v_tmp = {n_rem, n_qd[DVD_W-1]};
            n_qd  = {n_qd[DVD_W-2:0], 1'b0};
            if (v_tmp >= {1'b0, r_dsr}) begin
                n_rem    = DSR_W'(v_tmp - {1'b0, r_dsr});
                n_qd[0]  = 1'b1;
            end else begin
                n_rem = v_tmp[DSR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_qd  <= i_dividend;
            r_dsr <= i_divisor;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_qd  <= n_qd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= DIV_CNT_W'(r_cnt + 1'b1);
        end
    end

    assign o_quotient = r_qd;
    assign o_last     = (r_cnt == DIV_CNT_W'(DIV_ITERS - 1));

endmodule

// File: sv/savest_ctrl.sv
// ----------------------------------------------------------------------------
// savest_ctrl
// Sequencer: steps one item through decode, divide and averaging where needed, and update.
// ----------------------------------------------------------------------------
module savest_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    input  savest_pkg::t_status i_status,
    output savest_pkg::t_cmd    o_cmd
);
    import savest_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: n_state = ST_SETUP;
            ST_SETUP: begin
                n_state = (i_status.extrap || i_status.vel_upd) ? ST_LOAD : ST_APPLY;
            end
            ST_LOAD:   n_state = ST_DIVIDE;
            ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = i_status.extrap ? ST_APPLY : ST_CLAMP;
                end
            end
            ST_CLAMP:  n_state = ST_MULT;
            ST_MULT:   n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROUND;
            ST_ROUND:  n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            ST_DECODE: o_cmd.decode   = 1'b1;
            ST_SETUP:  o_cmd.setup    = 1'b1;
            ST_LOAD:   o_cmd.load     = 1'b1;
            ST_DIVIDE: o_cmd.div_step = 1'b1;
            ST_CLAMP:  o_cmd.clamp    = 1'b1;
            ST_MULT:   o_cmd.mult     = 1'b1;
            ST_SUM:    o_cmd.sum      = 1'b1;
            ST_ROUND:  o_cmd.round    = 1'b1;
            ST_APPLY:  o_cmd.apply    = 1'b1;
            ST_DONE:   o_cmd.out_load = i_out_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// File: sv/savest_dp.sv
// ----------------------------------------------------------------------------
// savest_dp
// Datapath: estimator state, angle scaling, divider and velocity averaging.
// ----------------------------------------------------------------------------
module savest_dp #(
    parameter int unsigned ANGLE_BITS = 16,
    parameter int unsigned TIME_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  savest_pkg::t_cmd                      i_cmd,
    output savest_pkg::t_status                   o_status,
    input  savest_pkg::t_cfg                      i_cfg,
    input  logic                                  i_opcode,
    input  logic signed [savest_pkg::POT_W-1:0]   i_pot,
    input  logic [savest_pkg::STAMP_W-1:0]        i_stamp,
    output logic [savest_pkg::ANGLE_OUT_W-1:0]    o_angle,
    output logic signed [savest_pkg::VEL_W-1:0]   o_velocity,
    output logic                                  o_extrap
);
    import savest_pkg::*;

    localparam int unsigned SCALE_W = 34;
    localparam int unsigned MEAS_W  = (ANGLE_BITS + 8 > SCALE_W) ? ANGLE_BITS + 8 : SCALE_W;
    localparam int unsigned PROD_W  = VEL_W + TIME_BITS;

    // captured item
    logic                     r_op;
    logic signed [POT_W-1:0]  r_pos;
    logic [TIME_BITS-1:0]     r_now;

    // estimator state
    logic [ANGLE_BITS-1:0]    r_angle;
    logic signed [VEL_W-1:0]  r_vel;
    logic [TIME_BITS-1:0]     r_last;
    logic [3:0]               r_skip_cnt;
    logic                     r_wdz;

    // per-item working values
    logic                     r_init;
    logic                     r_extrap;
    logic                     r_upd;
    logic [TIME_BITS-1:0]     r_elapsed;
    logic [ANGLE_BITS-1:0]    r_meas;
    logic                     r_vel_neg;
    logic [VEL_W-1:0]         r_vel_mag;
    logic [PROD_W-1:0]        r_prod;
    logic [ANGLE_BITS-1:0]    r_dmag;
    logic                     r_dneg;
    logic signed [MV_W-1:0]   r_mv;
    logic signed [ACC_W-1:0]  r_p1;
    logic signed [ACC_W-1:0]  r_p2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VEL_W-1:0]  r_vel_new;

    logic                     w_in_dz;
    logic                     w_skip;
    logic [TIME_BITS-1:0]     w_elapsed;
    logic signed [SCALE_W-1:0] w_scaled;
    logic signed [MEAS_W-1:0] w_scaled_ext;
    logic [ANGLE_BITS-1:0]    w_meas;
    logic [ANGLE_BITS-1:0]    w_diff;
    logic [PROD_W-1:0]        w_prod;
    logic [DVD_W-1:0]         w_dividend;
    logic [DSR_W-1:0]         w_divisor;
    logic [DVD_W-1:0]         w_quot;
    logic                     w_div_last;
    logic [MV_W-2:0]          w_mv_mag;
    logic [16:0]              w_keep;
    logic signed [ACC_W-1:0]  w_p1;
    logic signed [ACC_W-1:0]  w_p2;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shift;
    logic [ANGLE_BITS-1:0]    w_disp;

    // ---- decode ----
    assign w_in_dz   = (r_pos < i_cfg.dz_low) || (r_pos > i_cfg.dz_high);
    assign w_skip    = !w_in_dz && (r_skip_cnt < i_cfg.skip_n);
    assign w_elapsed = r_now - r_last;

    // pot counts * Q8.8 gain, round half up, wrap
    assign w_scaled     = SCALE_W'(r_pos) * SCALE_W'(signed'({1'b0, i_cfg.gain}))
                        + 34'sd128;
    assign w_scaled_ext = MEAS_W'(w_scaled);
    assign w_meas       = w_scaled_ext[8 +: ANGLE_BITS];

    // ---- setup ----
    assign w_prod = PROD_W'(r_vel_mag) * PROD_W'(r_elapsed);
    assign w_diff = r_meas - r_angle;

    // ---- divider load: |v*dt| / 1e6 or |delta|*1e6 / dt ----
    assign w_dividend = r_extrap
        ? DVD_W'(r_prod) + DVD_W'(HALF_SEC_US)
        : DVD_W'(r_dmag) * DVD_W'(US_PER_SEC) + DVD_W'(r_elapsed >> 1);
    assign w_divisor  = r_extrap ? DSR_W'(US_PER_SEC) : DSR_W'(r_elapsed);

    savest_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_last     (w_div_last)
    );

    // ---- averaging ----
    assign w_mv_mag = (w_quot > MEAS_LIMIT) ? MEAS_LIMIT[MV_W-2:0] : w_quot[MV_W-2:0];
    assign w_keep   = 17'h10000 - {1'b0, i_cfg.weight};
    assign w_p1     = signed'({1'b0, w_keep}) * r_vel;
    assign w_p2     = signed'({1'b0, i_cfg.weight}) * r_mv;
    // ties away from zero: +32768 at or above zero, +32767 below
    assign w_rnd    = r_acc + (r_acc[ACC_W-1] ? RND_NEG : RND_POS);
    assign w_shift  = w_rnd >>> 16;

    assign w_disp   = w_quot[ANGLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_pos <= i_pot;
            r_now <= i_stamp[TIME_BITS-1:0];
        end
        if (i_cmd.decode) begin
            r_elapsed <= w_elapsed;
            r_meas    <= w_meas;
            r_vel_neg <= r_vel[VEL_W-1];
            r_vel_mag <= r_vel[VEL_W-1] ? (~unsigned'(r_vel) + 1'b1) : unsigned'(r_vel);
        end
        if (i_cmd.setup) begin
            r_prod <= w_prod;
            r_dneg <= w_diff[ANGLE_BITS-1];
            r_dmag <= w_diff[ANGLE_BITS-1] ? (r_angle - r_meas) : w_diff;
        end
        if (i_cmd.clamp) begin
            r_mv <= r_dneg ? -signed'({1'b0, w_mv_mag}) : signed'({1'b0, w_mv_mag});
        end
        if (i_cmd.mult) begin
            r_p1 <= w_p1;
            r_p2 <= w_p2;
        end
        if (i_cmd.sum) begin
            r_acc <= r_p1 + r_p2;
        end
        if (i_cmd.round) begin
            if (w_shift > VEL_MAX) begin
                r_vel_new <= VEL_MAX[VEL_W-1:0];
            end else if (w_shift < VEL_MIN) begin
                r_vel_new <= VEL_MIN[VEL_W-1:0];
            end else begin
                r_vel_new <= w_shift[VEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle    <= '0;
            r_vel      <= '0;
            r_last     <= '0;
            r_skip_cnt <= '0;
            r_wdz      <= 1'b0;
            r_init     <= 1'b0;
            r_extrap   <= 1'b0;
            r_upd      <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                r_init   <= r_op;
                r_extrap <= !r_op && (w_in_dz || w_skip);
                r_upd    <= !r_op && !(w_in_dz || w_skip) && !r_wdz && (w_elapsed != '0);
                r_last   <= r_now;
                if (r_op || w_in_dz) begin
                    r_skip_cnt <= '0;
                end else if (w_skip) begin
                    r_skip_cnt <= 4'(r_skip_cnt + 4'd1);
                end
            end
            if (i_cmd.apply) begin
                if (r_init) begin
                    r_angle <= r_meas;
                    r_vel   <= '0;
                    r_wdz   <= 1'b0;
                end else if (r_extrap) begin
                    r_angle <= r_vel_neg ? (r_angle - w_disp) : (r_angle + w_disp);
                    r_wdz   <= 1'b1;
                end else begin
                    r_angle <= r_meas;
                    r_wdz   <= 1'b0;
                    if (r_upd) r_vel <= r_vel_new;
                end
            end
        end
    end

    assign o_status.extrap   = r_extrap;
    assign o_status.vel_upd  = r_upd;
    assign o_status.div_last = w_div_last;

    // angle scaled to 16 bits, 0x8000 = half a turn
    if (ANGLE_BITS >= ANGLE_OUT_W) begin : g_out_shr
        assign o_angle = r_angle[ANGLE_BITS-1 -: ANGLE_OUT_W];
    end else begin : g_out_shl
        assign o_angle = {r_angle, {(ANGLE_OUT_W-ANGLE_BITS){1'b0}}};
    end
    assign o_velocity = r_vel;
    assign o_extrap   = r_extrap;

endmodule

// File: sv/servo_angle_velocity_estimator_top.sv
// ----------------------------------------------------------------------------
// servo_angle_velocity_estimator_top
// Wrapped servo angle and filtered velocity from timestamped pot readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one item per pot reading; tuser is the opcode
//   (0 = update, 1 = reinitialize), tdata carries the signed reading and the
//   microsecond timestamp. Output stream (m_axis): one item per input item
//   with the 16-bit angle, the saturated velocity and the extrapolating flag.
//   Config port: write-only, one register per index, taken on any edge with
//   i_cfg_wr_en high; write only while the block is idle.
//   Reinitialize and readings that keep the velocity pass decode and setup
//   straight to the update; extrapolated readings also pass the shared
//   divider, which retires two quotient bits per cycle, and readings that
//   update the velocity pass the divider, then clamp, multiply, sum and
//   round. One item is worked at a time; the next is taken only once the
//   result has reached the output register.
//   The output register decouples the sides: a stalled receiver holds the
//   result, and the block still takes and works the next item, waiting
//   only to hand over its result. Reset clears angle, velocity, timestamp,
//   skip count and dead-zone flag, loads the default settings and empties
//   the output register.
// ----------------------------------------------------------------------------
module servo_angle_velocity_estimator_top #(
    parameter int unsigned ANGLE_BITS = 16,
    parameter int unsigned TIME_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [savest_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // pot_position, sample_time_us
    input  logic                                  i_s_axis_tuser,  // opcode
    // result items
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [savest_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // angle, velocity
    output logic                                  o_m_axis_tuser,  // extrapolating
    // configuration writes
    input  logic                                  i_cfg_wr_en,
    input  logic [savest_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [savest_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import savest_pkg::*;

    t_cfg                    r_cfg;
    t_cmd                    w_cmd;
    t_status                 w_status;
    logic                    w_out_free;
    logic [ANGLE_OUT_W-1:0]  w_angle;
    logic signed [VEL_W-1:0] w_velocity;
    logic                    w_extrap;

    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_tdata;
    logic                    r_m_tuser;

    // settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain    <= GAIN_RST;
            r_cfg.dz_low  <= DZ_LOW_RST;
            r_cfg.dz_high <= DZ_HIGH_RST;
            r_cfg.weight  <= WEIGHT_RST;
            r_cfg.skip_n  <= SKIP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_GAIN:    r_cfg.gain    <= i_cfg_wdata;
                CFG_DZ_LOW:  r_cfg.dz_low  <= signed'(i_cfg_wdata);
                CFG_DZ_HIGH: r_cfg.dz_high <= signed'(i_cfg_wdata);
                CFG_WEIGHT:  r_cfg.weight  <= i_cfg_wdata;
                CFG_SKIP:    r_cfg.skip_n  <= i_cfg_wdata[3:0];
                default:     ;  // unmapped index, write dropped
            endcase
        end
    end

    // output register may load when empty or being drained this cycle
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    savest_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    savest_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg      (r_cfg),
        .i_opcode   (i_s_axis_tuser),
        .i_pot      (signed'(i_s_axis_tdata[POT_W-1:0])),
        .i_stamp    (i_s_axis_tdata[POT_W +: STAMP_W]),
        .o_angle    (w_angle),
        .o_velocity (w_velocity),
        .o_extrap   (w_extrap)
    );

    assign o_s_axis_tready = w_cmd.in_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_m_tdata <= {unsigned'(w_velocity), w_angle};
            r_m_tuser <= w_extrap;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    // one item in flight: input closes right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready while an item is being worked");

    // a result is never written over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_m_valid || i_m_axis_tready))
        else $error("output register loaded while holding a stalled result");

    // results appear only from a finished item
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("output valid rose without a result load");

    // no item accepted while the output load is pending
    a_accept_vs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |-> !w_cmd.out_load)
        else $error("item accepted in the same cycle as a result load");

endmodule

// File: bench/servo_angle_velocity_estimator_top_tb.sv
// ----------------------------------------------------------------------------
// servo_angle_velocity_estimator_top_tb
// Self-checking bench for the servo angle / velocity estimator.
// ----------------------------------------------------------------------------
// Pot readings are queued by the stimulus process and driven on the input
// stream by a clocked driver with random gaps. Every accepted item is run
// through a bit-accurate estimator model kept in the bench; the result
// monitor compares each output item field by field with the oldest predicted
// result. Settings are rewritten between phases, only once the block has
// drained, and cover the register extremes.
// ----------------------------------------------------------------------------
module servo_angle_velocity_estimator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import savest_pkg::*;

    // Opcode carried on the input tuser bit
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_REINIT = 1'b1
    } op_e;

    typedef struct packed {
        op_e                op;
        logic signed [15:0] pos;
        logic [31:0]        stamp;
    } pot_item_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [31:0] velocity;
        logic               extrap;
    } est_result_t;

    // Highest index the config address can reach; indexes past CFG_SKIP are unmapped
    localparam int     CFG_IDX_LAST  = 7;
    localparam int     SETTLE_CYCLES = 8;     // idle margin before a settings change
    localparam int     DRAIN_CYCLES  = 60;    // margin after the last result before the final check
    localparam int     TIMEOUT_NS    = 1_000_000;
    localparam longint MEAS_CLAMP    = 64'sh0000_4000_0000_0000;
    localparam int     POS_MIN       = -32768;
    localparam int     POS_MAX       = 32767;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;   // pot_position, sample_time_us
    logic                  i_s_axis_tuser  = 1'b0;  // opcode
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;          // angle, velocity
    logic                  o_m_axis_tuser;          // extrapolating
    logic                  i_cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    servo_angle_velocity_estimator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Settings as the block should hold them
    logic [15:0]        gain_reg    = GAIN_RST;
    logic signed [15:0] dz_low_reg  = DZ_LOW_RST;
    logic signed [15:0] dz_high_reg = DZ_HIGH_RST;
    logic [15:0]        weight_reg  = WEIGHT_RST;
    logic [3:0]         skip_reg    = SKIP_RST;

    // Estimator state, all clear after reset
    logic [15:0] est_angle   = '0;
    longint      est_vel     = 0;
    logic [31:0] est_stamp   = '0;
    logic [3:0]  est_skipped = '0;
    bit          est_was_dz  = 1'b0;

    pot_item_t   reading_queue[$];
    est_result_t expected_results[$];
    int unsigned readings_pushed = 0;
    int unsigned results_seen    = 0;
    int unsigned err_cnt         = 0;

    // Handshakes seen at the last rising edge, and driver pacing
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;
    bit no_idle  = 1'b0;
    int tx_gap   = 0;
    int rx_stall = 0;

    // Stimulus generator state
    logic [31:0] gen_stamp = '0;
    int          gen_pos   = 0;

    // ------------------------------------------------------------------
    // Estimator model
    // ------------------------------------------------------------------

    // Signed division by a positive value, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // round(pos * gain / 256), half up, wrapped to the angle width
    function automatic logic [15:0] pot_to_angle(logic signed [15:0] pos);
        longint      p;
        longint      g;
        logic [63:0] prod;
        p    = pos;
        g    = gain_reg;
        prod = p * g + 128;
        return prod[23:8];
    endfunction

    function automatic est_result_t estimate_step(op_e op, logic signed [15:0] pos,
                                                  logic [31:0] now);
        logic [31:0]        el_bits;
        longint             elapsed;
        longint             us_sec;
        longint             delta;
        longint             meas_vel;
        longint             wt;
        longint             acc;
        logic [63:0]        disp;
        logic [15:0]        meas;
        logic signed [15:0] dlt;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        bit                 in_dz;
        bit                 skip;
        est_result_t        r;
        el_bits = now - est_stamp;
        elapsed = el_bits;
        us_sec  = US_PER_SEC;
        lo      = dz_low_reg;
        hi      = dz_high_reg;
        in_dz   = 1'b0;
        skip    = 1'b0;
        est_stamp = now;
        if (op == OP_REINIT) begin
            // angle taken even from a dead-zone reading
            est_angle   = pot_to_angle(pos);
            est_vel     = 0;
            est_skipped = '0;
            est_was_dz  = 1'b0;
        end else begin
            in_dz = (pos < lo) || (pos > hi);
            if (in_dz) begin
                est_skipped = '0;
            end else if (est_skipped < skip_reg) begin
                est_skipped = est_skipped + 4'd1;
                skip        = 1'b1;
            end
            if (in_dz || skip) begin
                disp       = div_nearest(est_vel * elapsed, us_sec);
                est_angle  = est_angle + disp[15:0];
                est_was_dz = 1'b1;
            end else begin
                meas = pot_to_angle(pos);
                // no average on the first trusted reading, none over zero time
                if (!est_was_dz && elapsed != 0) begin
                    dlt      = meas - est_angle;
                    delta    = dlt;
                    meas_vel = div_nearest(delta * us_sec, elapsed);
                    if (meas_vel > MEAS_CLAMP) meas_vel = MEAS_CLAMP;
                    if (meas_vel < -MEAS_CLAMP) meas_vel = -MEAS_CLAMP;
                    wt  = weight_reg;
                    acc = (65536 - wt) * est_vel + wt * meas_vel;
                    acc = div_nearest(acc, 65536);
                    if (acc > VEL_MAX) acc = VEL_MAX;
                    if (acc < VEL_MIN) acc = VEL_MIN;
                    est_vel = acc;
                end
                est_angle  = meas;
                est_was_dz = 1'b0;
            end
        end
        r.angle    = est_angle;
        r.velocity = est_vel[31:0];
        r.extrap   = in_dz || skip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle draws: over a third of the items go back to back
    // ------------------------------------------------------------------
    function automatic int draw_idle();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one item from the queue at a time, changes at negedge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : reading_driver
        pot_item_t nxt;
        logic      valid_nxt;
        valid_nxt = i_s_axis_tvalid;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && in_fire)
                valid_nxt = 1'b0;
            if (!valid_nxt) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (reading_queue.size() > 0) begin
                    nxt = reading_queue.pop_front();
                    i_s_axis_tdata <= {nxt.stamp, nxt.pos};
                    i_s_axis_tuser <= nxt.op;
                    valid_nxt = 1'b1;
                    tx_gap    = draw_idle();
                end
            end
        end
        i_s_axis_tvalid <= valid_nxt;
    end

    // ------------------------------------------------------------------
    // Output sink: random stall after each result taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        logic ready_nxt;
        ready_nxt = 1'b0;
        if (i_rst_n) begin
            if (out_fire)
                rx_stall = draw_idle();
            if (rx_stall > 0)
                rx_stall--;
            else
                ready_nxt = 1'b1;
        end
        i_m_axis_tready <= ready_nxt;
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict for the item taken at this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        est_result_t got;
        est_result_t want;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= i_s_axis_tvalid && o_s_axis_tready;
            out_fire <= o_m_axis_tvalid && i_m_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                got.angle    = o_m_axis_tdata[15:0];
                got.velocity = o_m_axis_tdata[47:16];
                got.extrap   = o_m_axis_tuser;
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: result with none expected: angle %0d velocity %0d extrap %0b",
                             $time, got.angle, got.velocity, got.extrap);
                end else begin
                    want = expected_results.pop_front();
                    if (got.angle !== want.angle) begin
                        err_cnt++;
                        $display("%0t ns: angle expected %0d, got %0d",
                                 $time, want.angle, got.angle);
                    end
                    if (got.velocity !== want.velocity) begin
                        err_cnt++;
                        $display("%0t ns: velocity expected %0d, got %0d",
                                 $time, want.velocity, got.velocity);
                    end
                    if (got.extrap !== want.extrap) begin
                        err_cnt++;
                        $display("%0t ns: extrapolating expected %0b, got %0b",
                                 $time, want.extrap, got.extrap);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_results.push_back(estimate_step(op_e'(i_s_axis_tuser),
                                                         i_s_axis_tdata[15:0],
                                                         i_s_axis_tdata[47:16]));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_reading(op_e op, logic signed [15:0] pos, logic [31:0] stamp);
        pot_item_t it;
        it.op    = op;
        it.pos   = pos;
        it.stamp = stamp;
        reading_queue.push_back(it);
        readings_pushed++;
    endtask

    // Every item gives one result, so the block is idle once all are back
    task automatic wait_idle();
        while (results_seen < readings_pushed)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_GAIN:    gain_reg    = val;
            CFG_DZ_LOW:  dz_low_reg  = val;
            CFG_DZ_HIGH: dz_high_reg = val;
            CFG_WEIGHT:  weight_reg  = val;
            CFG_SKIP:    skip_reg    = val[3:0];
            default:     ;   // unmapped index, write dropped
        endcase
    endtask

    task automatic load_settings(logic [15:0] gain, logic signed [15:0] lo,
                                 logic signed [15:0] hi, logic [15:0] wt, logic [3:0] skip_n);
        logic [11:0] pad;
        pad = $urandom;
        wait_idle();
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_DZ_LOW, lo);
        write_reg(CFG_DZ_HIGH, hi);
        write_reg(CFG_WEIGHT, wt);
        // upper bits of the skip write are don't-care
        write_reg(CFG_SKIP, {pad, skip_n});
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] stamp_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return 32'd0;
        if (pick < 13)
            return $urandom_range(1, 50);
        if (pick < 93)
            return $urandom_range(1000, 20000);
        return $urandom;
    endfunction

    // Mostly a slow pot walk inside the trusted window, with dead-zone
    // excursions, reinitializations and fully random readings mixed in
    task automatic random_readings(int unsigned n);
        int unsigned k;
        int unsigned pick;
        int          lo;
        int          hi;
        int          walk;
        int          dz_pos;
        lo = dz_low_reg;
        hi = dz_high_reg;
        for (k = 0; k < n; k++) begin
            pick      = $urandom_range(0, 99);
            gen_stamp = gen_stamp + stamp_step();
            if (pick < 5) begin
                queue_reading(OP_REINIT, gen_pos, gen_stamp);
            end else if (pick < 17) begin
                gen_stamp = $urandom;
                queue_reading(op_e'($urandom_range(0, 1)), $urandom_range(0, 65535), gen_stamp);
            end else if (pick < 27) begin
                walk = $urandom_range(1, 3000);
                dz_pos = $urandom_range(0, 1) ? lo - walk : hi + walk;
                if (dz_pos < POS_MIN) dz_pos = POS_MIN;
                if (dz_pos > POS_MAX) dz_pos = POS_MAX;
                queue_reading(OP_UPDATE, dz_pos, gen_stamp);
            end else begin
                walk    = $urandom_range(0, 400);
                gen_pos = gen_pos + walk - 200;
                if (lo <= hi) begin
                    if (gen_pos < lo) gen_pos = lo;
                    if (gen_pos > hi) gen_pos = hi;
                end
                if (gen_pos < POS_MIN) gen_pos = POS_MIN;
                if (gen_pos > POS_MAX) gen_pos = POS_MAX;
                queue_reading(OP_UPDATE, gen_pos, gen_stamp);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          lo;
        int          span;
        int          idx;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default settings: window -166..1162, skip one
        queue_reading(OP_UPDATE, 0, 32'd1000);          // held back right after reset
        queue_reading(OP_UPDATE, 500, 32'd2000);        // first trusted: no average
        queue_reading(OP_UPDATE, 600, 32'd3000);        // velocity average
        queue_reading(OP_UPDATE, 700, 32'd3000);        // zero elapsed: velocity kept
        queue_reading(OP_UPDATE, 32767, 32'd4000);      // above window: extrapolate
        queue_reading(OP_UPDATE, -32768, 32'd9000);     // below window
        queue_reading(OP_UPDATE, 1000, 32'd10000);      // skipped after the dead zone
        queue_reading(OP_UPDATE, 1162, 32'd11000);      // upper edge, no average
        queue_reading(OP_UPDATE, -166, 32'd12000);      // lower edge, wrapped delta
        queue_reading(OP_UPDATE, -167, 32'd13000);      // just below window
        queue_reading(OP_UPDATE, 1163, 32'd14000);      // just above window
        queue_reading(OP_REINIT, 32767, 32'hFFFF_FFF0); // reinit from a dead-zone reading
        queue_reading(OP_UPDATE, -166, 32'h0000_0010);  // timestamp wraps
        queue_reading(OP_UPDATE, 1162, 32'h0000_0020);
        queue_reading(OP_UPDATE, -166, 32'h0000_0021);  // 1 us apart: large velocity
        queue_reading(OP_UPDATE, 1162, 32'h0000_0022);
        queue_reading(OP_UPDATE, 0, 32'h8000_0022);     // half the timestamp range elapsed
        queue_reading(OP_UPDATE, 32767, 32'h0000_0021); // extrapolate over ~2^31 us
        queue_reading(OP_REINIT, -32768, 32'hFFFF_FFFF);
        gen_stamp = 32'hFFFF_FFFF;
        gen_pos   = 0;

        // Everything trusted, newest measurement weighted nearly fully, no skip
        load_settings(16'hFFFF, -16'sd32768, 16'sd32767, 16'hFFFF, 4'd0);
        // velocity saturates high, then low
        queue_reading(OP_REINIT, 0, gen_stamp + 32'd1);
        queue_reading(OP_UPDATE, 0, gen_stamp + 32'd2);
        queue_reading(OP_UPDATE, 100, gen_stamp + 32'd3);
        queue_reading(OP_UPDATE, 0, gen_stamp + 32'd4);
        gen_stamp = gen_stamp + 32'd4;
        random_readings(55);

        // Empty window: every update extrapolates; zero gain, zero weight
        load_settings(16'h0000, 16'sd32767, -16'sd32768, 16'h0000, 4'd15);
        no_idle = 1'b1;
        random_readings(40);

        // Narrow window with the longest skip run
        load_settings(16'd256, -16'sd1000, 16'sd1000, 16'h8000, 4'd15);
        no_idle = 1'b0;
        random_readings(30);
        // sender holds off until every result is back, then resumes
        wait_idle();
        random_readings(30);

        // Back to defaults; writes to unmapped indexes must change nothing
        load_settings(GAIN_RST, DZ_LOW_RST, DZ_HIGH_RST, WEIGHT_RST, SKIP_RST);
        for (idx = int'(CFG_SKIP) + 1; idx <= CFG_IDX_LAST; idx++)
            write_reg(idx, $urandom);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        random_readings(60);

        // Random settings, window kept mostly non-empty
        repeat (3) begin
            lo   = $urandom_range(0, 6000);
            lo   = lo - 4000;
            span = $urandom_range(0, 8000);
            load_settings($urandom, lo, lo + span, $urandom, $urandom_range(0, 15));
            gen_pos = lo + span / 2;
            no_idle = ($urandom_range(0, 3) == 0);
            random_readings(70);
        end

        while (results_seen < readings_pushed)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t ns: timeout, %0d of %0d results received",
                 $time, results_seen, readings_pushed);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/savest_pkg.sv
sv/savest_div.sv
sv/savest_ctrl.sv
sv/savest_dp.sv
sv/servo_angle_velocity_estimator_top.sv
bench/servo_angle_velocity_estimator_top_tb.sv
